### design/ifls_pkg.sv
`default_nettype none

package ifls_pkg;

  // Widths of the stored link words and of the byte arithmetic.
  localparam int LINK_W   = 9;
  localparam int INDEX_W  = 8;
  localparam int OFFSET_W = 32;
  localparam int SIZE_W   = 21;
  localparam int PROD_W   = INDEX_W + SIZE_W;

  // Link value that marks the end of the chain and an empty stack.
  localparam logic [LINK_W-1:0] EMPTY_MARK = 9'h1FF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] CFG_OBJECT_SIZE = 2'd1;
  localparam logic [1:0] CFG_BASE_OFFSET = 2'd2;

  typedef enum logic [1:0] {
    ACT_PUSH_INDEX  = 2'd0,
    ACT_PUSH_OFFSET = 2'd1,
    ACT_POP         = 2'd2,
    ACT_INIT        = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV_WAIT,
    S_PUSH,
    S_POP,
    S_INIT,
    S_MUL,
    S_ADD,
    S_REPORT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    div_start;
    logic    e_from_quot;
    logic    push_commit;
    logic    pop_commit;
    logic    init_write;
    logic    init_finish;
    logic    clear_result;
    status_t code;
    logic    take_offset;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    empty;
    logic    off_bad;
    logic    div_done;
    logic    quot_bad;
    logic    e_bad;
    logic    full;
    logic    n_zero;
    logic    init_last;
  } dp_sts_t;

endpackage

`default_nettype wire

### design/ifls_div.sv
`default_nettype none

module ifls_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ifls_pkg::OFFSET_W-1:0] dividend,
  input  wire logic [ifls_pkg::SIZE_W-1:0]   divisor,
  output logic                               done,
  output logic [ifls_pkg::OFFSET_W-1:0]      quotient,
  output logic [ifls_pkg::SIZE_W-1:0]        remainder
);
  import ifls_pkg::*;

  logic                 running;
  logic [4:0]           count;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      diff;
  logic                 ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {remainder, quotient[OFFSET_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  // Quotient bits shift in where the dividend bits shift out.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running   <= 1'b1;
        count     <= '0;
        remainder <= '0;
        quotient  <= dividend;
      end else if (running) begin
        remainder <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        quotient  <= {quotient[OFFSET_W-2:0], ge};
        count     <= count + 5'd1;
        if (count == 5'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/ifls_dp.sv
`default_nettype none

module ifls_dp #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ifls_pkg::dp_cmd_t             cmd,
  output ifls_pkg::dp_sts_t                  sts,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [ifls_pkg::OFFSET_W-1:0] cfg_data,
  input  wire logic [1:0]                    action,
  input  wire logic [ifls_pkg::INDEX_W-1:0]  req_index,
  input  wire logic [ifls_pkg::OFFSET_W-1:0] req_offset,
  output logic [ifls_pkg::INDEX_W-1:0]       result_index,
  output logic [ifls_pkg::OFFSET_W-1:0]      result_offset,
  output logic [ifls_pkg::LINK_W-1:0]        free_count,
  output logic [1:0]                         status
);
  import ifls_pkg::*;

  // Only 8-bit indices exist, so the table never needs more than 256 entries.
  localparam int IDX_LIMIT = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;
  localparam int AW        = $clog2(IDX_LIMIT);

  logic [LINK_W-1:0]   entry_count;
  logic [SIZE_W-1:0]   obj_bytes;
  logic [OFFSET_W-1:0] base_offset;

  action_t             act_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [INDEX_W-1:0]  e;
  logic [LINK_W-1:0]   top;
  logic [LINK_W-1:0]   free;
  logic [LINK_W-1:0]   cnt;
  logic [PROD_W-1:0]   prod;
  logic [LINK_W-1:0]   rd_data;
  logic [LINK_W-1:0]   eff_n;
  status_t             res_status;

  logic [LINK_W-1:0]   link_mem [IDX_LIMIT];
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [LINK_W-1:0]   mem_wd;

  logic                div_done;
  logic [OFFSET_W-1:0] quot;
  logic [SIZE_W-1:0]   rem;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 9'd256;
      obj_bytes   <= 21'd64;
      base_offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTRY_COUNT: entry_count <= cfg_data[LINK_W-1:0];
        CFG_OBJECT_SIZE: obj_bytes   <= cfg_data[SIZE_W-1:0];
        CFG_BASE_OFFSET: base_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // The count of chained entries is limited by the table depth.
  assign eff_n = (entry_count > LINK_W'(IDX_LIMIT)) ? LINK_W'(IDX_LIMIT) : entry_count;

  // The offset divider turns an offset into an index.
  ifls_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (offset_r - base_offset),
    .divisor   (obj_bytes),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  // Status toward the controller.
  always_comb begin
    sts.action    = act_r;
    sts.empty     = (free == '0) || (top >= LINK_W'(IDX_LIMIT));
    sts.off_bad   = (offset_r < base_offset) || (obj_bytes == '0);
    sts.div_done  = div_done;
    sts.quot_bad  = (rem != '0) || (quot[OFFSET_W-1:LINK_W] != '0) ||
                    (quot[LINK_W-1:0] >= eff_n);
    sts.e_bad     = {1'b0, e} >= eff_n;
    sts.full      = free >= eff_n;
    sts.n_zero    = eff_n == '0;
    sts.init_last = cnt == (eff_n - 9'd1);
  end

  // Stack pointer, free count and init counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      top  <= EMPTY_MARK;
      free <= '0;
      cnt  <= '0;
    end else begin
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.init_write) begin
        cnt <= cnt + 9'd1;
      end
      if (cmd.init_finish) begin
        top  <= sts.n_zero ? EMPTY_MARK : '0;
        free <= eff_n;
      end else if (cmd.push_commit) begin
        top  <= {1'b0, e};
        free <= free + 9'd1;
      end else if (cmd.pop_commit) begin
        top  <= rd_data;
        free <= free - 9'd1;
      end
    end
  end

  // Captured item fields and the entry being worked on.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= action_t'(action);
      offset_r <= req_offset;
      e        <= req_index;
    end else if (cmd.e_from_quot) begin
      e <= quot[INDEX_W-1:0];
    end else if (cmd.pop_commit) begin
      e <= top[INDEX_W-1:0];
    end
  end

  // Write port of the link table.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt[AW-1:0];
    mem_wd = sts.init_last ? EMPTY_MARK : cnt + 9'd1;
    if (cmd.init_write) begin
      mem_we = 1'b1;
    end else if (cmd.push_commit) begin
      mem_we = 1'b1;
      mem_wa = e[AW-1:0];
      mem_wd = top;
    end else if (cmd.pop_commit) begin
      mem_we = 1'b1;
      mem_wa = top[AW-1:0];
      mem_wd = EMPTY_MARK;
    end
  end

  // Link table; the link of the top entry is read every cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    rd_data <= link_mem[top[AW-1:0]];
  end

  // Offset of the current entry: multiply, then add the base in the next cycle.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(e) * PROD_W'(obj_bytes);
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.clear_result) begin
      result_index  <= '0;
      result_offset <= '0;
      res_status    <= cmd.code;
    end else if (cmd.take_offset) begin
      result_index  <= e;
      result_offset <= base_offset + OFFSET_W'(prod);
      res_status    <= ST_OK;
    end
  end

  assign status     = res_status;
  assign free_count = free;

  // The free count can never exceed the table depth.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free <= LINK_W'(IDX_LIMIT))
    else $error("free count above table depth");

  // A pop only commits on a non-empty stack.
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_commit |-> !sts.empty)
    else $error("pop committed on empty stack");

  // A push only commits for a valid index on a stack that is not full.
  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.push_commit |-> !sts.e_bad && !sts.full)
    else $error("push committed while bad or full");

  // A pushed entry becomes the new top.
  a_push_top: assert property (@(posedge clk) disable iff (rst)
    cmd.push_commit |=> top == {1'b0, $past(e)})
    else $error("pushed entry not on top");

endmodule

`default_nettype wire

### design/ifls_ctrl.sv
`default_nettype none

module ifls_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done,
  output ifls_pkg::dp_cmd_t      cmd,
  input  wire ifls_pkg::dp_sts_t sts
);
  import ifls_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = ST_OK;
    busy       = state != S_IDLE;
    done       = state == S_REPORT;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        unique case (sts.action)
          ACT_PUSH_INDEX: begin
            state_next = S_PUSH;
          end
          ACT_PUSH_OFFSET: begin
            if (sts.off_bad) begin
              cmd.clear_result = 1'b1;
              cmd.code         = ST_BAD;
              state_next       = S_REPORT;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV_WAIT;
            end
          end
          ACT_POP: begin
            if (sts.empty) begin
              cmd.clear_result = 1'b1;
              cmd.code         = ST_EMPTY;
              state_next       = S_REPORT;
            end else begin
              state_next = S_POP;
            end
          end
          ACT_INIT: begin
            if (sts.n_zero) begin
              cmd.init_finish  = 1'b1;
              cmd.clear_result = 1'b1;
              state_next       = S_REPORT;
            end else begin
              state_next = S_INIT;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          if (sts.quot_bad) begin
            cmd.clear_result = 1'b1;
            cmd.code         = ST_BAD;
            state_next       = S_REPORT;
          end else begin
            cmd.e_from_quot = 1'b1;
            state_next      = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        priority if (sts.e_bad) begin
          cmd.clear_result = 1'b1;
          cmd.code         = ST_BAD;
          state_next       = S_REPORT;
        end else if (sts.full) begin
          cmd.clear_result = 1'b1;
          cmd.code         = ST_FULL;
          state_next       = S_REPORT;
        end else begin
          cmd.push_commit = 1'b1;
          state_next      = S_MUL;
        end
      end
      S_POP: begin
        cmd.pop_commit = 1'b1;
        state_next     = S_MUL;
      end
      S_INIT: begin
        cmd.init_write = 1'b1;
        if (sts.init_last) begin
          cmd.init_finish  = 1'b1;
          cmd.clear_result = 1'b1;
          state_next       = S_REPORT;
        end
      end
      S_MUL: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.take_offset = 1'b1;
        state_next      = S_REPORT;
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The result strobe is a single-cycle pulse followed by an idle block.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");

  // An accepted item makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

endmodule

`default_nettype wire

### design/index_free_list_stack.sv
`default_nettype none

// Free-entry allocator kept as a linked stack of entry indices. An item is
// taken when start is high and busy is low; its single result appears for
// exactly one cycle with done high and must be captured then. A successful
// push by index or pop goes through the states PREP, PUSH or POP, MUL, ADD
// and REPORT, with one multiply stage and one add stage; a rejected item
// reports sooner. A push by offset first waits in DIV_WAIT for the
// one-bit-per-cycle divider. Initialize writes one link per cycle for each
// of the n entries, n being entry_count limited to the table depth.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while the block is idle.
module index_free_list_stack #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  req_index,
  input  wire logic [31:0] req_offset,
  output logic             done,
  output logic [7:0]       result_index,
  output logic [31:0]      result_offset,
  output logic [8:0]       free_count,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import ifls_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer for each action.
  ifls_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Link table, stack registers, offset arithmetic and result registers.
  ifls_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .req_index     (req_index),
    .req_offset    (req_offset),
    .result_index  (result_index),
    .result_offset (result_offset),
    .free_count    (free_count),
    .status        (status)
  );

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import ifls_pkg::*;

  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int ENTRY_LIMIT     = 256;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 158;
  localparam int SETTLE_CYCLES   = 8;

  // Register index that the block does not implement.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // One result of the allocator as it appears on the result ports.
  typedef struct packed {
    logic [7:0]  idx;
    logic [31:0] off;
    logic [8:0]  cnt;
    status_t     st;
  } alloc_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  action;
  logic [7:0]  req_index;
  logic [31:0] req_offset;
  logic        done;
  logic [7:0]  result_index;
  logic [31:0] result_offset;
  logic [8:0]  free_count;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // Shadow copy of the free-list state and configuration.
  logic [8:0]  link_tbl [ENTRY_LIMIT];
  logic [8:0]  stack_top;
  logic [8:0]  free_cnt;
  logic [8:0]  cfg_count;
  logic [20:0] cfg_size;
  logic [31:0] cfg_base;

  alloc_result_t pending_results[$];
  logic [7:0]    taken_entries[$];

  int errors;
  int results_seen;
  int cycle_count;
  int action_hits[4];
  int status_hits[4];
  int burst_left;
  bit steady;

  index_free_list_stack uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .req_index    (req_index),
    .req_offset   (req_offset),
    .done         (done),
    .result_index (result_index),
    .result_offset(result_offset),
    .free_count   (free_count),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Clock and run-length guard.
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Entries in play: the configured count, limited by the 8-bit index.
  function automatic int unsigned active_count();
    return (cfg_count > ENTRY_LIMIT) ? ENTRY_LIMIT : cfg_count;
  endfunction

  function automatic logic [31:0] entry_addr(int unsigned e);
    return cfg_base + e * cfg_size;
  endfunction

  // Applies one command to the shadow state and returns its result.
  function automatic alloc_result_t alloc_step(action_t act, logic [7:0] idx,
                                               logic [31:0] off);
    alloc_result_t r;
    int unsigned   n;
    int unsigned   e;
    logic [31:0]   diff;
    bit            bad;
    r    = '0;
    n    = active_count();
    e    = 0;
    bad  = 0;
    case (act)
      ACT_INIT: begin
        // Chain entries so that entry zero ends up on top.
        stack_top = EMPTY_MARK;
        free_cnt  = '0;
        for (int i = n; i > 0; i--) begin
          link_tbl[i-1] = stack_top;
          stack_top     = 9'(i - 1);
          free_cnt++;
        end
      end
      ACT_POP: begin
        if (free_cnt == 0 || stack_top >= ENTRY_LIMIT) begin
          r.st = ST_EMPTY;
        end else begin
          e             = 32'(stack_top);
          stack_top     = link_tbl[e];
          link_tbl[e]   = EMPTY_MARK;
          free_cnt--;
          r.idx = e[7:0];
          r.off = entry_addr(e);
        end
      end
      default: begin
        // Both push forms: resolve the entry, then range and fullness.
        if (act == ACT_PUSH_INDEX) begin
          e = 32'(idx);
        end else if (off < cfg_base || cfg_size == 0) begin
          bad = 1;
        end else begin
          diff = off - cfg_base;
          if (diff % cfg_size != 0) bad = 1;
          else e = diff / cfg_size;
        end
        if (!bad && e >= n) bad = 1;
        if (bad) begin
          r.st = ST_BAD;
        end else if (free_cnt >= n) begin
          r.st = ST_FULL;
        end else begin
          link_tbl[e] = stack_top;
          stack_top   = e[8:0];
          free_cnt++;
          r.idx = e[7:0];
          r.off = entry_addr(e);
        end
      end
    endcase
    r.cnt = free_cnt;
    return r;
  endfunction

  // Result checker and predictor, both working off the rising edge.
  always @(posedge clk) begin : result_monitor
    alloc_result_t want;
    if (rst) begin
      stack_top = EMPTY_MARK;
      free_cnt  = '0;
      cfg_count = 9'd256;
      cfg_size  = 21'd64;
      cfg_base  = '0;
      pending_results.delete();
      taken_entries.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result with no command outstanding: index %0d offset %h",
                 result_index, result_offset);
          errors++;
        end else begin
          want = pending_results.pop_front();
          results_seen++;
          if (result_index !== want.idx) begin
            $error("result_index: expected %0d, got %0d", want.idx, result_index);
            errors++;
          end
          if (result_offset !== want.off) begin
            $error("result_offset: expected %h, got %h", want.off, result_offset);
            errors++;
          end
          if (free_count !== want.cnt) begin
            $error("free_count: expected %0d, got %0d", want.cnt, free_count);
            errors++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENTRY_COUNT: cfg_count = cfg_data[8:0];
          CFG_OBJECT_SIZE: cfg_size  = cfg_data[20:0];
          CFG_BASE_OFFSET: cfg_base  = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        want = alloc_step(action_t'(action), req_index, req_offset);
        pending_results.push_back(want);
        action_hits[action]++;
        status_hits[want.st]++;
        // Track entries handed out so that the stimulus can return them.
        if (action == ACT_INIT) taken_entries.delete();
        else if (action == ACT_POP && want.st == ST_OK) taken_entries.push_back(want.idx);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(action_t act, logic [7:0] idx, logic [31:0] off);
    start      = 1'b1;
    action     = act;
    req_index  = idx;
    req_offset = off;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Inputs wander while start is low; the block must ignore them.
  task automatic idle_cycles(int n);
    repeat (n) begin
      start      = 1'b0;
      action     = 2'($urandom());
      req_index  = 8'($urandom());
      req_offset = $urandom();
      @(negedge clk);
    end
  endtask

  // Holds off until every outstanding result has arrived and the block is idle.
  task automatic wait_for_quiet();
    start = 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [31:0] count_data, logic [31:0] size_data,
                            logic [31:0] base_data);
    wait_for_quiet();
    cfg_write(CFG_ENTRY_COUNT, count_data);
    cfg_write(CFG_OBJECT_SIZE, size_data);
    cfg_write(CFG_BASE_OFFSET, base_data);
  endtask

  // Pops and pushes ahead of any initialize, using the reset configuration.
  task automatic test_before_init();
    send_item(ACT_POP, 8'($urandom()), $urandom());
    send_item(ACT_PUSH_INDEX, 8'd5, $urandom());
    send_item(ACT_PUSH_OFFSET, 8'($urandom()), 32'd448);
    send_item(ACT_POP, 8'($urandom()), $urandom());
    send_item(ACT_POP, 8'($urandom()), $urandom());
  endtask

  // Full, out-of-range and empty cases on a four-entry list.
  task automatic test_full_and_empty();
    set_config(32'd4, 32'd64, 32'd0);
    send_item(ACT_INIT, 8'($urandom()), $urandom());
    send_item(ACT_PUSH_INDEX, 8'd2, $urandom());
    send_item(ACT_PUSH_INDEX, 8'd4, $urandom());
    repeat (4) send_item(ACT_POP, 8'($urandom()), $urandom());
    send_item(ACT_POP, 8'($urandom()), $urandom());
    send_item(ACT_PUSH_INDEX, 8'd255, $urandom());
  endtask

  // Offset pushes: wraparound, below base, misaligned, aligned, zero size.
  task automatic test_offset_forms();
    set_config(32'd8, 32'h0010_0000, 32'hFFF0_0000);
    send_item(ACT_INIT, 8'($urandom()), $urandom());
    send_item(ACT_POP, 8'($urandom()), $urandom());
    send_item(ACT_POP, 8'($urandom()), $urandom());
    send_item(ACT_PUSH_OFFSET, 8'($urandom()), 32'h0000_0000);
    send_item(ACT_PUSH_OFFSET, 8'($urandom()), 32'hFFF0_0001);
    send_item(ACT_PUSH_OFFSET, 8'($urandom()), 32'hFFF0_0000);
    wait_for_quiet();
    cfg_write(CFG_OBJECT_SIZE, 32'd0);
    send_item(ACT_PUSH_OFFSET, 8'($urandom()), 32'hFFF0_0000);
  endtask

  // Zero entries, an oversized count and a write to an unused register.
  task automatic test_config_extremes();
    wait_for_quiet();
    cfg_write(CFG_UNUSED, $urandom());
    cfg_write(CFG_ENTRY_COUNT, 32'd0);
    send_item(ACT_INIT, 8'($urandom()), $urandom());
    send_item(ACT_POP, 8'($urandom()), $urandom());
    send_item(ACT_PUSH_INDEX, 8'd0, $urandom());
    wait_for_quiet();
    cfg_write(CFG_ENTRY_COUNT, 32'hABCD_E1FF);
    send_item(ACT_INIT, 8'($urandom()), $urandom());
  endtask

  // Sender pacing: bursts of back-to-back commands separated by short gaps, with no gaps while steady is set.
  task automatic pace();
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      idle_cycles($urandom_range(1, 10));
    end
    if (burst_left > 0) burst_left--;
  endtask

  // Mostly pops and returns of handed-out entries, with some malformed pushes and an occasional initialize.
  task automatic random_item();
    int unsigned n;
    int unsigned pick;
    int          k;
    logic [7:0]  idx;
    logic [31:0] off;
    n    = active_count();
    pick = $urandom_range(0, 99);
    idx  = 8'($urandom());
    off  = $urandom();
    if (pick < 36 || (pick < 80 && taken_entries.size() == 0)) begin
      send_item(ACT_POP, idx, off);
    end else if (pick < 80) begin
      k   = $urandom_range(0, taken_entries.size() - 1);
      idx = taken_entries[k];
      taken_entries.delete(k);
      if (pick < 58) send_item(ACT_PUSH_INDEX, idx, off);
      else send_item(ACT_PUSH_OFFSET, 8'($urandom()), entry_addr(idx));
    end else if (pick < 97) begin
      case ($urandom_range(0, 4))
        0: send_item(ACT_PUSH_INDEX, idx, off);
        1: send_item(ACT_PUSH_OFFSET, idx, off);
        2: send_item(ACT_PUSH_OFFSET, idx, entry_addr($urandom_range(0, n)) + 1);
        3: send_item(ACT_PUSH_OFFSET, idx, cfg_base - $urandom_range(1, 64));
        default: send_item(ACT_PUSH_OFFSET, idx, entry_addr(n));
      endcase
    end else begin
      send_item(ACT_INIT, idx, off);
    end
  endtask

  // Random traffic over a series of configurations, each started by initialize.
  task automatic test_random_traffic();
    logic [31:0] count_val;
    logic [31:0] size_val;
    logic [31:0] base_val;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          count_val = 32'd256;
          size_val  = 32'h0010_0000;
          base_val  = 32'hFFFF_FFFF;
        end
        1: begin
          count_val = 32'd1;
          size_val  = 32'd1;
          base_val  = 32'd0;
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       count_val = 32'd256;
            1:       count_val = $urandom_range(257, 511);
            2, 3:    count_val = $urandom_range(2, 12);
            default: count_val = 1 << $urandom_range(1, 6);
          endcase
          case ($urandom_range(0, 4))
            0:       size_val = 32'd1;
            1:       size_val = 32'd64;
            2:       size_val = 1 << $urandom_range(0, 20);
            default: size_val = $urandom_range(1, 1 << 20);
          endcase
          case ($urandom_range(0, 3))
            0:       base_val = 32'd0;
            1:       base_val = $urandom();
            2:       base_val = 32'hFFFF_FFFF - $urandom_range(0, 4096);
            default: base_val = $urandom_range(0, 1 << 16) * 64;
          endcase
        end
      endcase
      // Bits above each register's width are don't-care on the write data.
      if ($urandom_range(0, 1)) begin
        count_val = ($urandom() & 32'hFFFF_FE00) | count_val;
        size_val  = ($urandom() & 32'hFFE0_0000) | size_val;
      end
      set_config(count_val, size_val, base_val);
      steady     = (p % 4 == 1);
      burst_left = 0;
      send_item(ACT_INIT, 8'($urandom()), $urandom());
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 5 && k == ITEMS_PER_PHASE / 2) wait_for_quiet();
        pace();
        random_item();
      end
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    action       = '0;
    req_index    = '0;
    req_offset   = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    errors       = 0;
    results_seen = 0;
    cycle_count  = 0;
    burst_left   = 0;
    steady       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_before_init();
    test_full_and_empty();
    test_offset_forms();
    test_config_extremes();
    test_random_traffic();
    wait_for_quiet();

    $display("Checked %0d results: %0d push by index, %0d push by offset, %0d pop, %0d init.",
             results_seen, action_hits[ACT_PUSH_INDEX], action_hits[ACT_PUSH_OFFSET],
             action_hits[ACT_POP], action_hits[ACT_INIT]);
    $display("Outcomes: %0d ok, %0d empty, %0d full, %0d bad index or offset.",
             status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_FULL],
             status_hits[ST_BAD]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/ifls_pkg.sv
design/ifls_div.sv
design/ifls_dp.sv
design/ifls_ctrl.sv
design/index_free_list_stack.sv
tb/tb.sv
